// ----- rtl/arcb_pkg.sv -----
// ----------------------------------------------------------------------------
// arcb_pkg
// Shared constants and the result record of the address range to CIDR core.
// ----------------------------------------------------------------------------
package arcb_pkg;

  // Port widths of the address and prefix fields.
  localparam int FIELD_W  = 32;
  localparam int PREFIX_W = 6;

  // Default width of the address arithmetic.
  localparam int ADDRESS_BITS_DEFAULT = 32;

  // A single range never produces more blocks than this.
  localparam int RESULT_CAP = 62;
  localparam int COUNT_W    = $clog2(RESULT_CAP);

  // Depths of the range queue and the result queue.
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef struct packed {
    logic [FIELD_W-1:0]  network_address;
    logic [PREFIX_W-1:0] prefix_length;
    logic                missing_result;
    logic                last_block;
  } result_t;

endpackage

// ----- rtl/address_range_to_cidr_blocks_core.sv -----
// ----------------------------------------------------------------------------
// address_range_to_cidr_blocks_core
// Splits an inclusive address range into its minimal run of CIDR blocks.
// ----------------------------------------------------------------------------
// Each accepted beat carries two range bounds in either order; the core
// returns the CIDR blocks that cover the range exactly, lowest first, one
// result beat per block, with last_block set on the final one. A missing
// bound yields a single result with missing_result set. The front end orders
// the bounds and queues the range; the back end loads it, then walks it,
// producing one block per cycle while the result queue is not full; a range
// yields at most 62 blocks. Input and result queues of two entries each let
// either side stall without stopping the other.
module address_range_to_cidr_blocks_core #(
  parameter int ADDRESS_BITS = arcb_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [arcb_pkg::FIELD_W-1:0]  first_address,
  input  logic [arcb_pkg::FIELD_W-1:0]  second_address,
  input  logic                          either_missing,
  input  logic                          pop,
  output logic                          empty,
  output logic [arcb_pkg::FIELD_W-1:0]  network_address,
  output logic [arcb_pkg::PREFIX_W-1:0] prefix_length,
  output logic                          missing_result,
  output logic                          last_block
);

  import arcb_pkg::*;

  localparam int CMD_W = 2 * ADDRESS_BITS + 1;

  logic             cmd_push;
  logic [CMD_W-1:0] cmd_wdata;
  logic             cmd_full;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_rdata;
  logic             cmd_empty;
  logic             res_push;
  result_t          res_wdata;
  logic             res_full;
  result_t          res_rdata;

  arcb_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .push           (push),
    .full           (full),
    .first_address  (first_address),
    .second_address (second_address),
    .either_missing (either_missing),
    .cmd_push       (cmd_push),
    .cmd_data       (cmd_wdata),
    .cmd_full       (cmd_full)
  );

  arcb_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  arcb_back #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_wdata),
    .res_full  (res_full)
  );

  arcb_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign network_address = res_rdata.network_address;
  assign prefix_length   = res_rdata.prefix_length;
  assign missing_result  = res_rdata.missing_result;
  assign last_block      = res_rdata.last_block;

endmodule

// ----- rtl/arcb_fifo.sv -----
// ----------------------------------------------------------------------------
// arcb_fifo
// Small synchronous queue with push/full and pop/empty on a register array.
// ----------------------------------------------------------------------------
module arcb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == DEPTH_CNT);
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/arcb_front.sv -----
// ----------------------------------------------------------------------------
// arcb_front
// Accepts ranges, orders the two bounds and forwards them to the range queue.
// ----------------------------------------------------------------------------
module arcb_front #(
  parameter int ADDRESS_BITS = 32
) (
  input  logic                        push,
  output logic                        full,
  input  logic [arcb_pkg::FIELD_W-1:0] first_address,
  input  logic [arcb_pkg::FIELD_W-1:0] second_address,
  input  logic                        either_missing,
  output logic                        cmd_push,
  output logic [2*ADDRESS_BITS:0]     cmd_data,
  input  logic                        cmd_full
);

  import arcb_pkg::*;

  logic [ADDRESS_BITS-1:0] addr_a;
  logic [ADDRESS_BITS-1:0] addr_b;
  logic [ADDRESS_BITS-1:0] addr_lo;
  logic [ADDRESS_BITS-1:0] addr_hi;

  assign addr_a = ADDRESS_BITS'(first_address);
  assign addr_b = ADDRESS_BITS'(second_address);

  always_comb begin
    if (addr_a < addr_b) begin
      addr_lo = addr_a;
      addr_hi = addr_b;
    end else begin
      addr_lo = addr_b;
      addr_hi = addr_a;
    end
  end

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;
  assign cmd_data = {either_missing, addr_hi, addr_lo};

endmodule

// ----- rtl/arcb_back.sv -----
// ----------------------------------------------------------------------------
// arcb_back
// Walks one ordered range, emitting one aligned CIDR block per cycle unless the result queue is full.
// ----------------------------------------------------------------------------
module arcb_back #(
  parameter int ADDRESS_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_empty,
  input  logic [2*ADDRESS_BITS:0] cmd_data,
  output logic                    cmd_pop,
  output logic                    res_push,
  output arcb_pkg::result_t       res_data,
  input  logic                    res_full
);

  import arcb_pkg::*;

  localparam int AW  = ADDRESS_BITS;
  localparam int K_W = $clog2(AW + 1);
  localparam logic [K_W-1:0] AW_K = K_W'(AW);
  localparam logic [COUNT_W-1:0] CAP_LAST = COUNT_W'(RESULT_CAP - 1);

  // Index of the lowest set bit; the full width when nothing is set.
  function automatic logic [K_W-1:0] low_index(input logic [AW-1:0] v);
    logic [AW-1:0] iso;
    logic [K_W-1:0] idx;
    iso = v & (~v + 1'b1);
    idx = '0;
    for (int i = 0; i < AW; i++) begin
      if (iso[i]) begin
        idx = idx | K_W'(i);
      end
    end
    if (v == '0) begin
      idx = AW_K;
    end
    return idx;
  endfunction

  function automatic logic [AW-1:0] reverse(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) begin
      r[i] = v[AW-1-i];
    end
    return r;
  endfunction

  logic               busy;
  logic               miss;
  logic [AW-1:0]      block;
  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic [COUNT_W-1:0] count;

  logic [AW-1:0]  diff;
  logic [K_W-1:0] high_diff;
  logic [K_W-1:0] trail_ones;
  logic [K_W-1:0] trail_zeros;
  logic [K_W-1:0] wide;
  logic [K_W-1:0] k;
  logic [AW:0]    one_shift;
  logic [AW-1:0]  host_mask;
  logic [AW:0]    sum;
  logic [AW-1:0]  next;
  logic [K_W-1:0] prefix;
  logic           last;
  logic           emit;

  assign diff        = block ^ hi;
  assign high_diff   = AW_K - 1'b1 - low_index(reverse(diff));
  assign trail_ones  = low_index(~diff);
  assign trail_zeros = low_index(block);
  assign wide        = (high_diff > trail_ones) ? high_diff : trail_ones;
  assign k           = (block == hi) ? '0
                     : ((trail_zeros < wide) ? trail_zeros : wide);

  // Block size 2^k; the host mask is all ones when k covers the full width.
  assign one_shift = {{AW{1'b0}}, 1'b1} << k;
  assign host_mask = AW'(one_shift - 1'b1);
  assign sum       = {1'b0, block | host_mask} + 1'b1;
  assign next      = sum[AW-1:0];
  assign prefix    = AW_K - k;

  // A next start at or below the low bound means the run wrapped past all ones.
  assign last = (next > hi) || (next <= lo) || (count == CAP_LAST);

  assign emit    = busy && !res_full;
  assign cmd_pop = !busy && !cmd_empty;

  assign res_push = emit;
  always_comb begin
    if (miss) begin
      res_data.network_address = '0;
      res_data.prefix_length   = '0;
      res_data.missing_result  = 1'b1;
      res_data.last_block      = 1'b1;
    end else begin
      res_data.network_address = FIELD_W'(block);
      res_data.prefix_length   = PREFIX_W'(prefix);
      res_data.missing_result  = 1'b0;
      res_data.last_block      = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd_pop) begin
      busy <= 1'b1;
    end else if (emit && (miss || last)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      miss  <= cmd_data[2*AW];
      hi    <= cmd_data[2*AW-1:AW];
      lo    <= cmd_data[AW-1:0];
      block <= cmd_data[AW-1:0];
      count <= '0;
    end else if (emit) begin
      block <= next;
      count <= count + 1'b1;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the address range to CIDR core against its own block-splitting model.
// ----------------------------------------------------------------------------
// A table of hand-picked ranges runs first, then random ranges of many shapes
// in four phases: no idling, an idle sender, a stalling receiver, and both.
// Every result beat is compared field by field with the oldest block still
// owed.

module testbench;
  import arcb_pkg::*;

  localparam int ADDR_BITS     = ADDRESS_BITS_DEFAULT;
  localparam int RANDOM_RANGES = 62;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int NUM_PHASES    = 4;
  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 54, 0, 25};
  localparam int POP_STALL_PCT [NUM_PHASES] = '{0, 0, 54, 25};

  typedef struct packed {
    logic [FIELD_W-1:0] addr_a;
    logic [FIELD_W-1:0] addr_b;
    logic               missing;
    logic               typed;
    result_t            want;
  } range_case_t;

  localparam int NUM_DIRECTED = 23;
  localparam range_case_t DIRECTED_RANGES [NUM_DIRECTED] = '{
    '{32'h00000000, 32'h00000000, 1'b1, 1'b1, '{32'h00000000, 6'd0,  1'b1, 1'b1}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, '{32'h00000000, 6'd0,  1'b1, 1'b1}},
    '{32'h12345678, 32'h9ABCDEF0, 1'b1, 1'b1, '{32'h00000000, 6'd0,  1'b1, 1'b1}},
    '{32'h00000000, 32'h00000000, 1'b0, 1'b1, '{32'h00000000, 6'd32, 1'b0, 1'b1}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, '{32'hFFFFFFFF, 6'd32, 1'b0, 1'b1}},
    '{32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b1, '{32'h00000000, 6'd0,  1'b0, 1'b1}},
    '{32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b1, '{32'h00000000, 6'd0,  1'b0, 1'b1}},
    '{32'h80000000, 32'hFFFFFFFF, 1'b0, 1'b1, '{32'h80000000, 6'd1,  1'b0, 1'b1}},
    '{32'h00000001, 32'hFFFFFFFE, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'hFFFFFFFE, 32'h00000001, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'h00000000, 32'h00000001, 1'b0, 1'b1, '{32'h00000000, 6'd31, 1'b0, 1'b1}},
    '{32'h00000001, 32'h00000002, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'h00000000, 32'hFFFFFFFE, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'h00000001, 32'hFFFFFFFF, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'hC0000001, 32'hFFFFFFFF, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'h0A000000, 32'h0AFFFFFF, 1'b0, 1'b1, '{32'h0A000000, 6'd8,  1'b0, 1'b1}},
    '{32'h00000000, 32'h7FFFFFFF, 1'b0, 1'b1, '{32'h00000000, 6'd1,  1'b0, 1'b1}},
    '{32'hAAAAAAAA, 32'h55555555, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'h55555555, 32'h55555555, 1'b0, 1'b1, '{32'h55555555, 6'd32, 1'b0, 1'b1}},
    '{32'hC0A800FE, 32'hC0A80001, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'h12345678, 32'h12345679, 1'b0, 1'b0, '{32'h00000000, 6'd0,  1'b0, 1'b0}},
    '{32'hFFFFFFFE, 32'hFFFFFFFF, 1'b0, 1'b1, '{32'hFFFFFFFE, 6'd31, 1'b0, 1'b1}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [FIELD_W-1:0]  first_address = '0;
  logic [FIELD_W-1:0]  second_address = '0;
  logic                either_missing = 1'b0;
  logic                pop = 1'b0;
  logic                empty;
  logic [FIELD_W-1:0]  network_address;
  logic [PREFIX_W-1:0] prefix_length;
  logic                missing_result;
  logic                last_block;

  result_t pending_blocks [$];
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  int      send_idle_pct = 0;
  int      pop_stall_pct = 0;

  address_range_to_cidr_blocks_core #(
    .ADDRESS_BITS(ADDR_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .first_address  (first_address),
    .second_address (second_address),
    .either_missing (either_missing),
    .pop            (pop),
    .empty          (empty),
    .network_address(network_address),
    .prefix_length  (prefix_length),
    .missing_result (missing_result),
    .last_block     (last_block)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Trailing zero bits; the full width when the value is zero.
  function automatic int trailing_zero_count(input logic [FIELD_W-1:0] v);
    int n;
    n = 0;
    while (n < ADDR_BITS && !v[n]) n++;
    return n;
  endfunction

  // Adds one block to the tail of the blocks still owed.
  function automatic void owe_block(input result_t blk);
    pending_blocks.insert(pending_blocks.size(), blk);
  endfunction

  // Appends the run of blocks that covers the range to the blocks still owed.
  function automatic void cover_range_with_blocks(input logic [FIELD_W-1:0] a, b,
                                                  input logic miss);
    logic [FIELD_W-1:0] lo, hi, start, span, nxt;
    int                 k, hd, tone, tz, wide, count;
    logic               stop;
    if (miss) begin
      owe_block(result_t'{'0, '0, 1'b1, 1'b1});
      return;
    end
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    start = lo;
    count = 0;
    stop = 1'b0;
    while (!stop) begin
      k = 0;
      if (start != hi) begin
        span = start ^ hi;
        hd = 0;
        for (int i = 0; i < ADDR_BITS; i++) begin
          if (span[i]) hd = i;
        end
        tone = trailing_zero_count(~span);
        tz = trailing_zero_count(start);
        wide = (hd > tone) ? hd : tone;
        k = (tz < wide) ? tz : wide;
      end
      nxt = (start | FIELD_W'((33'd1 << k) - 33'd1)) + 1'b1;
      // A start that wraps to zero is never above the low bound.
      stop = (nxt > hi) || (nxt <= lo) || (count == RESULT_CAP - 1);
      owe_block(result_t'{start, PREFIX_W'(ADDR_BITS - k), 1'b0, stop});
      count++;
      start = nxt;
    end
  endfunction

  function automatic void check_field(input string label,
                                      input logic [FIELD_W-1:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, label, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_range(input logic [FIELD_W-1:0] a, b, input logic miss,
                            input logic typed, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    first_address <= a;
    second_address <= b;
    either_missing <= miss;
    @(posedge clk);
    while (full) @(posedge clk);
    if (typed) owe_block(want);
    else cover_range_with_blocks(a, b, miss);
    @(negedge clk);
  endtask

  // Spans are drawn on a log scale so that short, medium and huge runs all occur.
  task automatic pick_random_range(output logic [FIELD_W-1:0] a, b, output logic miss);
    int                 shape, k;
    logic [FIELD_W-1:0] lo, hi, tmp;
    shape = $urandom_range(99);
    miss = 1'b0;
    lo = $urandom();
    hi = $urandom();
    if (shape < 5) begin
      miss = 1'b1;
    end else if (shape < 50) begin
      if (shape >= 30) hi = lo + $urandom_range(300);
    end else if (shape < 65) begin
      k = $urandom_range(32);
      lo = lo & ~FIELD_W'((33'd1 << k) - 33'd1);
      hi = lo + FIELD_W'((33'd1 << $urandom_range(k)) - 33'd1);
    end else if (shape < 80) begin
      hi = '1;
      lo = hi - (FIELD_W'($urandom()) >> $urandom_range(31));
    end else if (shape < 90) begin
      lo = $urandom_range(15);
      hi = FIELD_W'($urandom()) >> $urandom_range(31);
    end else begin
      hi = lo;
    end
    if ($urandom_range(1)) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    a = lo;
    b = hi;
  endtask

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin : check_blocks
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected block beat, expected none, got %h/%0d miss=%b last=%b",
                 $time, network_address, prefix_length, missing_result, last_block);
        mismatch_count++;
      end else begin
        want = pending_blocks.pop_front();
        check_field("network_address", want.network_address, network_address);
        check_field("prefix_length", FIELD_W'(want.prefix_length), FIELD_W'(prefix_length));
        check_field("missing_result", FIELD_W'(want.missing_result),
                    FIELD_W'(missing_result));
        check_field("last_block", FIELD_W'(want.last_block), FIELD_W'(last_block));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] a, b;
    logic               miss;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = SEND_IDLE_PCT[ph];
      pop_stall_pct = POP_STALL_PCT[ph];
      if (ph == 0) begin
        foreach (DIRECTED_RANGES[i]) begin
          send_range(DIRECTED_RANGES[i].addr_a, DIRECTED_RANGES[i].addr_b,
                     DIRECTED_RANGES[i].missing, DIRECTED_RANGES[i].typed,
                     DIRECTED_RANGES[i].want);
        end
      end
      repeat (RANDOM_RANGES) begin
        pick_random_range(a, b, miss);
        send_range(a, b, miss, 1'b0, '0);
      end
    end
    push <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
